/* hw/rtl/assert_macros.svh */
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion macros shared by the RTL; define ASSERT_OFF to drop them all.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// Whenever ante holds at a clock edge, cons must hold at the same edge.
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// cond must hold at every clock edge out of reset.
`define ASSERT_ALWAYS(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("assertion failed");

`else

`define ASSERT_IMPLY(label, clk, rst_n, ante, cons)
`define ASSERT_ALWAYS(label, clk, rst_n, cond)

`endif

`endif

/* hw/rtl/kvt_pkg.sv */
// ----------------------------------------------------------------------------
// kvt_pkg
// Types and operation codes shared by the key-value table and its cells.
// ----------------------------------------------------------------------------
package kvt_pkg;

    localparam int KeyWidth   = 31;
    localparam int ValueWidth = 31;

    localparam logic [1:0] KIND_PUT    = 2'd0;
    localparam logic [1:0] KIND_GET    = 2'd1;
    localparam logic [1:0] KIND_REMOVE = 2'd2;
    localparam logic [1:0] KIND_NOP    = 2'd3;

    typedef struct packed {
        logic [1:0]            kind;
        logic [KeyWidth-1:0]   lookup_key;
        logic [ValueWidth-1:0] store_value;
    } cmd_t;

    typedef struct packed {
        logic                  hit;
        logic [ValueWidth-1:0] read_value;
        logic                  table_full;
    } result_t;

    // Token that walks the cell row: a search pass, then a commit pass if needed.
    typedef struct packed {
        logic                  active;
        logic                  commit;
        logic [1:0]            kind;
        logic [KeyWidth-1:0]   key;
        logic [ValueWidth-1:0] value;
        logic                  found;
        logic [ValueWidth-1:0] found_value;
        logic                  free_seen;
        logic                  placed;
    } tok_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_COMMIT
    } state_t;

endpackage

/* hw/rtl/kvt_cell.sv */
// ----------------------------------------------------------------------------
// kvt_cell
// One table slot: holds key, value and valid mark, and passes the token on.
// ----------------------------------------------------------------------------
module kvt_cell (
    input  logic          clk,
    input  logic          rst_n,
    input  kvt_pkg::tok_t tok_in,
    output kvt_pkg::tok_t tok_out
);

    logic [kvt_pkg::KeyWidth-1:0]   key_reg;
    logic [kvt_pkg::ValueWidth-1:0] value_reg;
    logic                           valid_reg;
    logic                           valid_next;
    kvt_pkg::tok_t                  tok_reg;
    kvt_pkg::tok_t                  tok_next;
    logic                           match;
    logic                           is_search;
    logic                           is_commit;
    logic                           write_new;
    logic                           write_upd;
    logic                           clear;

    assign match     = valid_reg && (key_reg == tok_in.key);
    assign is_search = tok_in.active && !tok_in.commit;
    assign is_commit = tok_in.active && tok_in.commit;

    // Take the first free slot on the way only if the key was absent.
    assign write_new = is_commit && (tok_in.kind == kvt_pkg::KIND_PUT) && !tok_in.found
                       && !tok_in.placed && !valid_reg;
    assign write_upd = is_commit && (tok_in.kind == kvt_pkg::KIND_PUT) && tok_in.found
                       && match;
    assign clear     = is_commit && (tok_in.kind == kvt_pkg::KIND_REMOVE) && match;

    always_comb
    begin
        tok_next = tok_in;
        if (is_search)
        begin
            if (match)
            begin
                tok_next.found       = 1'b1;
                tok_next.found_value = value_reg;
            end
            if (!valid_reg)
            begin
                tok_next.free_seen = 1'b1;
            end
        end
        if (write_new)
        begin
            tok_next.placed = 1'b1;
        end

        if (write_new)
        begin
            valid_next = 1'b1;
        end
        else if (clear)
        begin
            valid_next = 1'b0;
        end
        else
        begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            tok_reg   <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
            tok_reg   <= tok_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (write_new)
        begin
            key_reg <= tok_in.key;
        end
        if (write_new || write_upd)
        begin
            value_reg <= tok_in.value;
        end
    end

    assign tok_out = tok_reg;

endmodule

/* hw/rtl/key_value_table.sv */
// ----------------------------------------------------------------------------
// key_value_table
// Bounded key-value table built as a row of slot cells walked by a token.
// ----------------------------------------------------------------------------
// An item is taken when start is high and busy is low. It travels down the
// row of ENTRIES slot cells, one cell per cycle, to search for the key, the
// stored value and a free slot. A get, a missing remove, a dropped put or an
// unused kind then finishes: done pulses from a register once the token leaves
// the last cell. A put that stores and a remove that hits make a second pass
// down the row to commit the change, and done pulses once that pass is through.
// busy falls in the cycle that done is high, so the next item may be taken
// right then. The result holds until the next item ends its search pass; the
// receiver cannot stall it. Reset empties the table at once.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module key_value_table #(
    parameter int ENTRIES = 64
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    output logic             busy,
    input  kvt_pkg::cmd_t    cmd,
    output logic             done,
    output kvt_pkg::result_t result
);

    kvt_pkg::tok_t    chain [ENTRIES+1];
    kvt_pkg::tok_t    head;
    kvt_pkg::tok_t    tail;
    kvt_pkg::state_t  state_reg;
    kvt_pkg::state_t  state_next;
    logic             done_reg;
    logic             done_next;
    kvt_pkg::result_t result_reg;
    kvt_pkg::result_t result_next;
    logic             need_commit;
    logic [ENTRIES-1:0] act_vec;

    assign chain[0] = head;
    assign tail     = chain[ENTRIES];

    generate
        for (genvar i = 0; i < ENTRIES; i++)
        begin : g_cell
            kvt_cell u_cell (
                .clk     (clk),
                .rst_n   (rst_n),
                .tok_in  (chain[i]),
                .tok_out (chain[i+1])
            );
            assign act_vec[i] = chain[i+1].active;
        end
    endgenerate

    assign need_commit = ((tail.kind == kvt_pkg::KIND_PUT) && (tail.found || tail.free_seen))
                         || ((tail.kind == kvt_pkg::KIND_REMOVE) && tail.found);

    always_comb
    begin
        state_next  = state_reg;
        done_next   = 1'b0;
        result_next = result_reg;
        head        = '0;
        unique case (state_reg)
            kvt_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    head.active = 1'b1;
                    head.kind   = cmd.kind;
                    head.key    = cmd.lookup_key;
                    head.value  = cmd.store_value;
                    state_next  = kvt_pkg::ST_SEARCH;
                end
            end
            kvt_pkg::ST_SEARCH:
            begin
                if (tail.active)
                begin
                    result_next.hit        = tail.found && (tail.kind != kvt_pkg::KIND_NOP);
                    result_next.read_value = (tail.found && (tail.kind == kvt_pkg::KIND_GET))
                                             ? tail.found_value : '0;
                    result_next.table_full = (tail.kind == kvt_pkg::KIND_PUT) && !tail.found
                                             && !tail.free_seen;
                    if (need_commit)
                    begin
                        // Send the token round again to apply the change.
                        head        = tail;
                        head.commit = 1'b1;
                        state_next  = kvt_pkg::ST_COMMIT;
                    end
                    else
                    begin
                        done_next  = 1'b1;
                        state_next = kvt_pkg::ST_IDLE;
                    end
                end
            end
            kvt_pkg::ST_COMMIT:
            begin
                if (tail.active)
                begin
                    done_next  = 1'b1;
                    state_next = kvt_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = kvt_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= kvt_pkg::ST_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    assign busy   = (state_reg != kvt_pkg::ST_IDLE);
    assign done   = done_reg;
    assign result = result_reg;

    `ASSERT_ALWAYS(a_one_token, clk, rst_n, $onehot0(act_vec))
    `ASSERT_IMPLY(a_token_busy, clk, rst_n, tail.active, state_reg != kvt_pkg::ST_IDLE)
    `ASSERT_IMPLY(a_done_idle, clk, rst_n, done, state_reg == kvt_pkg::ST_IDLE)
    `ASSERT_IMPLY(a_full_no_hit, clk, rst_n, done && result.table_full, !result.hit)
    `ASSERT_IMPLY(a_value_on_hit, clk, rst_n, done && (result.read_value != '0), result.hit)

endmodule

/* tb/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the key-value table.
// ----------------------------------------------------------------------------
// Sends puts, gets, removes and unused kinds through the start/busy handshake.
// A shadow copy of the table predicts each result. Every done strobe is
// checked against the oldest prediction. The run starts with hand-picked
// items: both key extremes, overwrite of a present key, removal of slot 0,
// misses and the unused kind. Random phases follow over a pool of keys that
// is larger than the table, so the table fills and drops puts.
// ----------------------------------------------------------------------------
module tb;
    import kvt_pkg::*;

    localparam int Entries    = 64;
    localparam int PoolSize   = 72;
    localparam int Latency    = 2 * Entries + 1;
    localparam int StallLimit = 4 * Latency + 64;

    // Shadow of the table plus the results it still owes.
    class kv_mirror;
        logic [KeyWidth-1:0]   slot_key   [Entries];
        logic [ValueWidth-1:0] slot_value [Entries];
        bit                    slot_used  [Entries];
        result_t               owed_results [$];
        int                    error_count;
        int                    kind_count [4];
        int                    hit_count;
        int                    full_count;

        function void note_op(cmd_t c);
            result_t r;
            int      found_at;
            int      free_at;
            r        = '0;
            found_at = -1;
            free_at  = -1;
            for (int i = 0; i < Entries; i++)
            begin
                if (found_at < 0 && slot_used[i] && slot_key[i] == c.lookup_key)
                    found_at = i;
                if (free_at < 0 && !slot_used[i])
                    free_at = i;
            end
            case (c.kind)
                KIND_PUT:
                begin
                    if (found_at >= 0)
                    begin
                        slot_value[found_at] = c.store_value;
                        r.hit = 1'b1;
                    end
                    else if (free_at >= 0)
                    begin
                        slot_key[free_at]   = c.lookup_key;
                        slot_value[free_at] = c.store_value;
                        slot_used[free_at]  = 1'b1;
                    end
                    else
                        r.table_full = 1'b1;
                end
                KIND_GET:
                begin
                    if (found_at >= 0)
                    begin
                        r.hit        = 1'b1;
                        r.read_value = slot_value[found_at];
                    end
                end
                KIND_REMOVE:
                begin
                    if (found_at >= 0)
                    begin
                        slot_used[found_at] = 1'b0;
                        r.hit = 1'b1;
                    end
                end
                default:
                begin
                end
            endcase
            kind_count[c.kind]++;
            hit_count  += r.hit;
            full_count += r.table_full;
            owed_results.push_back(r);
        endfunction

        function void check_result(result_t got);
            result_t want;
            if (owed_results.size() == 0)
            begin
                $display("%0t: result with no item outstanding: expected none, actual %p",
                         $time, got);
                error_count++;
                return;
            end
            want = owed_results.pop_front();
            if (got.hit !== want.hit)
            begin
                $display("%0t: hit mismatch: expected %b, actual %b",
                         $time, want.hit, got.hit);
                error_count++;
            end
            if (got.read_value !== want.read_value)
            begin
                $display("%0t: read_value mismatch: expected %h, actual %h",
                         $time, want.read_value, got.read_value);
                error_count++;
            end
            if (got.table_full !== want.table_full)
            begin
                $display("%0t: table_full mismatch: expected %b, actual %b",
                         $time, want.table_full, got.table_full);
                error_count++;
            end
        endfunction

        function int pending();
            return owed_results.size();
        endfunction
    endclass

    logic    clk   = 1'b0;
    logic    rst_n = 1'b0;
    logic    start = 1'b0;
    cmd_t    cmd   = '0;
    logic    busy;
    logic    done;
    result_t result;

    kv_mirror              mirror = new();
    bit                    allow_idle = 1'b1;
    logic [KeyWidth-1:0]   key_pool [PoolSize];
    int                    fill_index = 0;

    key_value_table #(
        .ENTRIES(Entries)
    ) u_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .cmd   (cmd),
        .done  (done),
        .result(result)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Check the finishing item before noting the one taken at the same edge.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (done)
                mirror.check_result(result);
            if (start && !busy)
                mirror.note_op(cmd);
        end
    end

    initial
    begin : watchdog
        int stall;
        stall = 0;
        while (stall < StallLimit)
        begin
            @(posedge clk);
            if (!rst_n || (start && !busy) || done)
                stall = 0;
            else
                stall++;
        end
        $display("%0t: no handshake for %0d cycles, stopping", $time, StallLimit);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // Hold start until the item is taken, then maybe idle for a burst.
    task automatic send_op(input logic [1:0] kind, input logic [KeyWidth-1:0] key,
                           input logic [ValueWidth-1:0] value);
        cmd_t c;
        c.kind        = kind;
        c.lookup_key  = key;
        c.store_value = value;
        start <= 1'b1;
        cmd   <= c;
        do @(posedge clk); while (busy);
        if (allow_idle && $urandom_range(0, 2) == 0)
        begin
            start <= 1'b0;
            cmd   <= cmd_t'({$urandom, $urandom});
            // Sometimes let the block finish first so the gap lands on idle.
            if ($urandom_range(0, 1) == 1)
                do @(posedge clk); while (busy);
            repeat ($urandom_range(1, 16)) @(posedge clk);
        end
    endtask

    task automatic drain();
        start <= 1'b0;
        while (mirror.pending() != 0)
            @(posedge clk);
    endtask

    // Random items over the key pool; fill mode walks the pool with puts.
    task automatic run_random(input int count, input int put_w, input int get_w,
                              input int rem_w, input bit fill_mode);
        logic [1:0]          kind;
        logic [KeyWidth-1:0] key;
        int                  roll;
        for (int n = 0; n < count; n++)
        begin
            roll = $urandom_range(0, 99);
            if (roll < put_w)
                kind = KIND_PUT;
            else if (roll < put_w + get_w)
                kind = KIND_GET;
            else if (roll < put_w + get_w + rem_w)
                kind = KIND_REMOVE;
            else
                kind = KIND_NOP;
            if (fill_mode && kind == KIND_PUT)
            begin
                key = key_pool[fill_index % PoolSize];
                fill_index++;
            end
            else if ($urandom_range(0, 99) < 85)
                key = key_pool[$urandom_range(0, PoolSize - 1)];
            else
                key = KeyWidth'($urandom);
            send_op(kind, key, ValueWidth'($urandom));
        end
    endtask

    initial
    begin
        for (int i = 0; i < PoolSize; i++)
            key_pool[i] = KeyWidth'($urandom);
        key_pool[0] = '0;
        key_pool[1] = '1;

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Misses on the empty table, both key extremes, overwrite, unused kind.
        send_op(KIND_GET,    31'h0000_0000, 31'h7FFF_FFFF);
        send_op(KIND_REMOVE, 31'h7FFF_FFFF, 31'h0000_0000);
        send_op(KIND_PUT,    31'h0000_0000, 31'h0000_0000);
        send_op(KIND_PUT,    31'h7FFF_FFFF, 31'h7FFF_FFFF);
        send_op(KIND_GET,    31'h0000_0000, 31'h2AAA_AAAA);
        send_op(KIND_GET,    31'h7FFF_FFFF, 31'h5555_5555);
        send_op(KIND_PUT,    31'h0000_0000, 31'h7FFF_FFFF);
        send_op(KIND_GET,    31'h0000_0000, 31'h0000_0000);
        send_op(KIND_NOP,    31'h0000_0000, 31'h1234_5678);
        send_op(KIND_NOP,    31'h5555_5555, 31'h7FFF_FFFF);
        // Free slot 0, then make sure the next new key lands there.
        send_op(KIND_REMOVE, 31'h0000_0000, 31'h7FFF_FFFF);
        send_op(KIND_GET,    31'h0000_0000, 31'h0000_0000);
        send_op(KIND_REMOVE, 31'h0000_0000, 31'h0000_0000);
        send_op(KIND_PUT,    31'h2AAA_AAAA, 31'h5555_5555);
        send_op(KIND_GET,    31'h2AAA_AAAA, 31'h0000_0000);
        send_op(KIND_GET,    31'h7FFF_FFFF, 31'h0000_0000);
        send_op(KIND_PUT,    31'h5555_5555, 31'h2AAA_AAAA);
        send_op(KIND_GET,    31'h5555_5555, 31'h7FFF_FFFF);
        send_op(KIND_REMOVE, 31'h7FFF_FFFF, 31'h2AAA_AAAA);
        send_op(KIND_GET,    31'h7FFF_FFFF, 31'h7FFF_FFFF);
        send_op(KIND_PUT,    31'h5555_5555, 31'h0000_0000);
        drain();

        // Fill past capacity so puts of new keys get dropped.
        run_random(150, 80, 12, 4, 1'b1);
        drain();
        run_random(150, 35, 35, 22, 1'b0);

        // Close out back to back with no gaps.
        allow_idle = 1'b0;
        run_random(80, 35, 35, 22, 1'b0);
        start <= 1'b0;

        while (mirror.pending() != 0)
            @(posedge clk);
        repeat (Latency + 8) @(posedge clk);

        $display("Ran %0d puts, %0d gets, %0d removes, %0d unused kinds",
                 mirror.kind_count[KIND_PUT], mirror.kind_count[KIND_GET],
                 mirror.kind_count[KIND_REMOVE], mirror.kind_count[KIND_NOP]);
        $display("Saw %0d hits and %0d puts dropped on a full table",
                 mirror.hit_count, mirror.full_count);
        if (mirror.error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
